[hdl/prrs_pkg.sv]
// Shared constants and types for the priority round-robin scheduler.
`timescale 1ns / 1ps

package prrs_pkg;

  localparam int CAPACITY_DEFAULT = 16;

  localparam int PRIO_W   = 8;
  localparam int TICKS_W  = 16;
  localparam int STATUS_W = 3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_RUN    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PENDING  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTIED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd5;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [TICKS_W-1:0] ticks;
  } entry_t;

  localparam int ENTRY_W = PRIO_W + TICKS_W;

endpackage

[hdl/prrs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module prrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/priority_round_robin_scheduler.sv]
// Priority round-robin scheduler: task table in RAM with a shifting sequencer.
//
// Input channel (in_valid / in_stall) carries one item: kind selects an
// insert of a task (new_priority, new_time) or a run of one tick on the
// task at the cursor. Output channel (out_valid / out_stall) returns exactly
// one item per input item: status, ran_priority, time_left and task_count.
//
// The task table sits in one RAM, kept sorted by ascending priority. An
// insert walks down from the last entry, moving each entry of equal or larger
// priority (at the head, only a larger one) up one place per cycle until the
// slot is found; a finished run closes the gap by moving the following
// entries down, also one per cycle. The single RAM port pair sets the pace:
// one entry moved per cycle.
// The block takes one item at a time; in_stall is high while an item is
// in progress. A finished result waits in the output register while the
// next item is already worked on; a stalled result is held unchanged and
// only the completion of the following item waits for it.
// Reset (rst, synchronous) empties the table and returns the cursor to the
// head; no clearing pass is needed.
`timescale 1ns / 1ps

module priority_round_robin_scheduler
  import prrs_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT,
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [PRIO_W-1:0]   new_priority,
  input  logic [TICKS_W-1:0]  new_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [PRIO_W-1:0]   ran_priority,
  output logic [TICKS_W-1:0]  time_left,
  output logic [CNT_W-1:0]    task_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  logic [2:0]          state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [IDX_W-1:0]    cursor, cursor_next;
  logic [IDX_W-1:0]    ptr, ptr_next;
  logic [IDX_W-1:0]    cur, cur_next;
  logic [PRIO_W-1:0]   req_prio, req_prio_next;
  logic [TICKS_W-1:0]  req_ticks, req_ticks_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [PRIO_W-1:0]   res_prio, res_prio_next;
  logic [TICKS_W-1:0]  res_ticks, res_ticks_next;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_entry;
  logic [IDX_W-1:0]    rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  entry_t              rd_entry;

  logic [CNT_W:0]      count_ext;
  logic [CNT_W:0]      ptr_ext;
  logic [CNT_W:0]      cur_ext;
  logic [IDX_W-1:0]    cur_sel;
  logic                move_up;
  logic                load_out;

  assign rd_entry  = entry_t'(rd_data);
  assign count_ext = {1'b0, count};
  assign ptr_ext   = (CNT_W + 1)'(ptr);
  assign cur_ext   = (CNT_W + 1)'(cur);
  // a cursor past the last entry counts as the head
  assign cur_sel   = ((CNT_W + 1)'(cursor) >= count_ext) ? '0 : cursor;
  // head compares strictly below, the rest compare equal or above
  assign move_up   = (ptr == '0) ? (req_prio < rd_entry.prio) : (rd_entry.prio >= req_prio);
  assign in_stall  = (state != S_IDLE);
  assign load_out  = (state == S_DONE) && (!out_valid || !out_stall);

  prrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    cursor_next     = cursor;
    ptr_next        = ptr;
    cur_next        = cur;
    req_prio_next   = req_prio;
    req_ticks_next  = req_ticks;
    res_status_next = res_status;
    res_prio_next   = res_prio;
    res_ticks_next  = res_ticks;
    wr_en           = 1'b0;
    wr_addr         = ptr;
    wr_entry        = rd_entry;
    rd_addr         = ptr;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_prio_next  = new_priority;
          req_ticks_next = new_time;
          res_prio_next  = '0;
          res_ticks_next = '0;
          if (kind == KIND_INSERT) begin
            if (count == FULL_COUNT) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else if (count == '0) begin
              wr_en           = 1'b1;
              wr_addr         = '0;
              wr_entry        = '{prio: new_priority, ticks: new_time};
              count_next      = CNT_W'(1);
              cursor_next     = '0;
              res_status_next = ST_INSERTED;
              state_next      = S_DONE;
            end else begin
              ptr_next   = IDX_W'(count - CNT_W'(1));
              rd_addr    = IDX_W'(count - CNT_W'(1));
              state_next = S_INS;
            end
          end else begin
            if (count == '0) begin
              cursor_next     = '0;
              res_status_next = ST_IDLE;
              state_next      = S_DONE;
            end else begin
              cur_next   = cur_sel;
              rd_addr    = cur_sel;
              state_next = S_RUN;
            end
          end
        end
      end

      S_INS: begin
        // rd_entry is the entry at ptr; fetch the one below for the next step
        rd_addr = ptr - IDX_W'(1);
        wr_en   = 1'b1;
        wr_addr = ptr + IDX_W'(1);
        if (move_up) begin
          wr_entry = rd_entry;
          if (ptr == '0) begin
            state_next = S_PUT;
          end else begin
            ptr_next = ptr - IDX_W'(1);
          end
        end else begin
          wr_entry        = '{prio: req_prio, ticks: req_ticks};
          count_next      = count + CNT_W'(1);
          cursor_next     = '0;
          res_status_next = ST_INSERTED;
          state_next      = S_DONE;
        end
      end

      S_PUT: begin
        wr_en           = 1'b1;
        wr_addr         = '0;
        wr_entry        = '{prio: req_prio, ticks: req_ticks};
        count_next      = count + CNT_W'(1);
        cursor_next     = '0;
        res_status_next = ST_INSERTED;
        state_next      = S_DONE;
      end

      S_RUN: begin
        // early fetch of the successor in case the entry finishes
        rd_addr       = IDX_W'(cur_ext + (CNT_W + 1)'(1));
        res_prio_next = rd_entry.prio;
        if (rd_entry.ticks > TICKS_W'(1)) begin
          wr_en           = 1'b1;
          wr_addr         = cur;
          wr_entry        = '{prio: rd_entry.prio, ticks: rd_entry.ticks - TICKS_W'(1)};
          cursor_next     = (cur_ext + (CNT_W + 1)'(1) == count_ext) ? '0 : cur + IDX_W'(1);
          res_ticks_next  = rd_entry.ticks - TICKS_W'(1);
          res_status_next = ST_PENDING;
          state_next      = S_DONE;
        end else begin
          res_ticks_next = '0;
          if (cur_ext + (CNT_W + 1)'(1) < count_ext) begin
            ptr_next   = cur;
            state_next = S_SHIFT;
          end else begin
            count_next = count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              cursor_next     = '0;
              res_status_next = ST_EMPTIED;
            end else begin
              cursor_next     = (cur_ext >= count_ext - (CNT_W + 1)'(1)) ? '0 : cur;
              res_status_next = ST_FINISHED;
            end
            state_next = S_DONE;
          end
        end
      end

      S_SHIFT: begin
        // rd_entry is the entry at ptr + 1, moved down into ptr
        wr_en    = 1'b1;
        wr_addr  = ptr;
        wr_entry = rd_entry;
        rd_addr  = IDX_W'(ptr_ext + (CNT_W + 1)'(2));
        ptr_next = ptr + IDX_W'(1);
        if (ptr_ext + (CNT_W + 1)'(2) >= count_ext) begin
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            cursor_next     = '0;
            res_status_next = ST_EMPTIED;
          end else begin
            cursor_next     = (cur_ext >= count_ext - (CNT_W + 1)'(1)) ? '0 : cur;
            res_status_next = ST_FINISHED;
          end
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      cursor <= cursor_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    cur        <= cur_next;
    req_prio   <= req_prio_next;
    req_ticks  <= req_ticks_next;
    res_status <= res_status_next;
    res_prio   <= res_prio_next;
    res_ticks  <= res_ticks_next;
    if (load_out) begin
      status       <= res_status;
      ran_priority <= res_prio;
      time_left    <= res_ticks;
      task_count   <= count;
    end
  end

endmodule

[hdl/prrs_checker.sv]
// Port-level checks for the priority round-robin scheduler, bound to the top level.
`timescale 1ns / 1ps

module prrs_checker
  import prrs_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic [PRIO_W-1:0]   ran_priority,
  input logic [TICKS_W-1:0]  time_left,
  input logic [CNT_W-1:0]    task_count
);

  // one item at a time: an accepted item closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on the cycle after an accepted item");

  // inserts never report a run entry
  a_insert_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INSERTED || status == ST_FULL)
      |-> ran_priority == '0 && time_left == '0)
    else $error("insert result carries run fields");

  // a rejected insert means the table was full; an emptied or idle table holds nothing
  a_count_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_EMPTIED || status == ST_IDLE)
      |-> (status == ST_FULL) ? (task_count == CNT_W'(CAPACITY)) : (task_count == '0))
    else $error("task count disagrees with status");

  // a pending run always leaves time, a finishing one none
  a_run_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_PENDING || status == ST_FINISHED)
      |-> (status == ST_PENDING) == (time_left != '0))
    else $error("time left disagrees with run status");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(task_count))
    else $error("stalled result changed");

endmodule

bind priority_round_robin_scheduler prrs_checker #(
  .CAPACITY (CAPACITY)
) u_prrs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .ran_priority (ran_priority),
  .time_left    (time_left),
  .task_count   (task_count)
);
